// File: design/wlf_pkg.sv
`timescale 1ns / 1ps

package wlf_pkg;

    localparam int WINDOW = 8;

    localparam int LW  = $clog2(WINDOW);
    localparam int AW  = (LW > 0) ? LW : 1;
    localparam int XW  = 32;
    localparam int SXW = XW + LW;          // sum of x or y
    localparam int SQW = 2 * XW + LW;      // sum of x*x or x*y
    localparam int DW  = 2 * XW + 2 * LW;  // denominator and slope numerator
    localparam int NW  = SQW + SXW;        // intercept numerator
    localparam int QNW = NW + 16;          // scaled dividend
    localparam int MCW = $clog2(SXW);
    localparam int DCW = $clog2(QNW);
    localparam int SLW = 32;
    localparam int ICW = 48;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MXX,
        ST_MXY,
        ST_MLOAD,
        ST_MUL,
        ST_MSTORE,
        ST_DLOAD,
        ST_DIV,
        ST_DSTORE,
        ST_OUT
    } state_t;

endpackage

// File: design/windowed_line_fit.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata[63:0]: remote_tick, local_time
// m_axis    out        tdata[79:0]: slope, intercept; tuser[0]: fit_failed
//
// A beat is taken only in ST_IDLE, and no new beat is taken until the last one is done:
// each ring slot is read in ST_READ, ST_MXX and ST_MXY through the single memory read
// port and one 32x32 multiplier, then come four shift-add products in ST_MLOAD, ST_MUL
// and ST_MSTORE, and two restoring divides in ST_DLOAD, ST_DIV and ST_DSTORE.
// A failed fit skips the divides. A stalled output adds its wait.
// Reset clears the slot valid flags, so unwritten slots read as zero at once.
// A finished result waits in the output register while the next beat is taken.

module windowed_line_fit
    import wlf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // remote_tick[31:0], local_time[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // slope[31:0], intercept[79:32]
    output logic [0:0]  m_axis_tuser    // fit_failed[0]
);

    logic [2*XW-1:0] ring_mem [WINDOW];
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [2*XW-1:0] rdata_reg;
    logic            rvalid_reg;

    state_t state_reg, state_next;
    logic [AW-1:0] wslot_reg, wslot_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [SXW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [SQW-1:0] sxx_reg, sxx_next, sxy_reg, sxy_next;
    logic [SQW-1:0] mcand_reg, mcand_next;
    logic [NW-1:0]  prod_reg, prod_next;
    logic [MCW-1:0] mcnt_reg, mcnt_next;
    logic [1:0]     msel_reg, msel_next;
    logic [DW-1:0]  den_reg, den_next, num_m_reg, num_m_next;
    logic           neg_m_reg, neg_m_next, neg_c_reg, neg_c_next;
    logic [NW-1:0]  p3_reg, p3_next, num_c_reg, num_c_next;
    logic [QNW-1:0] num_reg, num_next;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic           dsel_reg, dsel_next;
    logic [SLW-1:0] slope_res_reg, slope_res_next;
    logic [ICW-1:0] icpt_res_reg, icpt_res_next;
    logic           failed_reg, failed_next;
    logic           out_valid_reg, out_valid_next;
    logic [79:0]    out_data_reg, out_data_next;
    logic           out_fail_reg, out_fail_next;

    logic           in_fire;
    logic [XW-1:0]  rx, ry;
    logic [2*XW-1:0] mul_out;
    logic [DW-1:0]  wsxx, wsxy;
    logic [SQW:0]   mul_sum;
    logic [DW:0]    div_sh;
    logic           div_ge;
    logic           sl_over_p, sl_over_n, ic_over_p, ic_over_n;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_fail_reg;

    assign rx = rvalid_reg ? rdata_reg[XW-1:0] : '0;
    assign ry = rvalid_reg ? rdata_reg[2*XW-1:XW] : '0;
    assign mul_out = rx * ((state_reg == ST_MXX) ? rx : ry);

    assign wsxx = DW'(sxx_reg) * DW'(WINDOW);
    assign wsxy = DW'(sxy_reg) * DW'(WINDOW);

    // Shift-add product: the multiplier sits in the low bits of prod_reg.
    assign mul_sum = {1'b0, prod_reg[NW-1:SXW]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);

    assign div_sh = {rem_reg, num_reg[QNW-1]};
    assign div_ge = (div_sh >= {1'b0, den_reg});

    assign sl_over_p = |num_reg[QNW-1:SLW-1];
    assign sl_over_n = (|num_reg[QNW-1:SLW]) || (num_reg[SLW-1] && (|num_reg[SLW-2:0]));
    assign ic_over_p = |num_reg[QNW-1:ICW-1];
    assign ic_over_n = (|num_reg[QNW-1:ICW]) || (num_reg[ICW-1] && (|num_reg[ICW-2:0]));

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ring_mem[wslot_reg] <= s_axis_tdata;
        end
        rdata_reg <= ring_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            wslot_reg     <= '0;
            rd_idx_reg    <= '0;
            mcnt_reg      <= '0;
            msel_reg      <= '0;
            dcnt_reg      <= '0;
            dsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rvalid_reg    <= valid_reg[rd_idx_reg];
            wslot_reg     <= wslot_next;
            rd_idx_reg    <= rd_idx_next;
            mcnt_reg      <= mcnt_next;
            msel_reg      <= msel_next;
            dcnt_reg      <= dcnt_next;
            dsel_reg      <= dsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        sxx_reg       <= sxx_next;
        sxy_reg       <= sxy_next;
        mcand_reg     <= mcand_next;
        prod_reg      <= prod_next;
        den_reg       <= den_next;
        num_m_reg     <= num_m_next;
        neg_m_reg     <= neg_m_next;
        neg_c_reg     <= neg_c_next;
        p3_reg        <= p3_next;
        num_c_reg     <= num_c_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        slope_res_reg <= slope_res_next;
        icpt_res_reg  <= icpt_res_next;
        failed_reg    <= failed_next;
        out_data_reg  <= out_data_next;
        out_fail_reg  <= out_fail_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        wslot_next     = wslot_reg;
        rd_idx_next    = rd_idx_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sxx_next       = sxx_reg;
        sxy_next       = sxy_reg;
        mcand_next     = mcand_reg;
        prod_next      = prod_reg;
        mcnt_next      = mcnt_reg;
        msel_next      = msel_reg;
        den_next       = den_reg;
        num_m_next     = num_m_reg;
        neg_m_next     = neg_m_reg;
        neg_c_next     = neg_c_reg;
        p3_next        = p3_reg;
        num_c_next     = num_c_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        dsel_next      = dsel_reg;
        slope_res_next = slope_res_reg;
        icpt_res_next  = icpt_res_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_fail_next  = out_fail_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    valid_next[wslot_reg] = 1'b1;
                    wslot_next  = (wslot_reg == AW'(WINDOW - 1)) ? '0 : wslot_reg + 1'b1;
                    rd_idx_next = '0;
                    sx_next     = '0;
                    sy_next     = '0;
                    sxx_next    = '0;
                    sxy_next    = '0;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MXX;
            end
            ST_MXX:
            begin
                sx_next    = sx_reg + SXW'(rx);
                sy_next    = sy_reg + SXW'(ry);
                sxx_next   = sxx_reg + SQW'(mul_out);
                state_next = ST_MXY;
            end
            ST_MXY:
            begin
                sxy_next = sxy_reg + SQW'(mul_out);
                if (rd_idx_reg == AW'(WINDOW - 1))
                begin
                    msel_next  = '0;
                    state_next = ST_MLOAD;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_MLOAD:
            begin
                mcnt_next = '0;
                case (msel_reg)
                    2'd0:
                    begin
                        mcand_next = SQW'(sx_reg);
                        prod_next  = NW'(sx_reg);
                    end
                    2'd1:
                    begin
                        mcand_next = SQW'(sy_reg);
                        prod_next  = NW'(sx_reg);
                    end
                    2'd2:
                    begin
                        mcand_next = sxx_reg;
                        prod_next  = NW'(sy_reg);
                    end
                    default:
                    begin
                        mcand_next = sxy_reg;
                        prod_next  = NW'(sx_reg);
                    end
                endcase
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next = {mul_sum, prod_reg[SXW-1:1]};
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MCW'(SXW - 1))
                begin
                    state_next = ST_MSTORE;
                end
            end
            ST_MSTORE:
            begin
                msel_next  = msel_reg + 1'b1;
                state_next = ST_MLOAD;
                case (msel_reg)
                    2'd0:
                    begin
                        den_next = wsxx - prod_reg[DW-1:0];
                    end
                    2'd1:
                    begin
                        neg_m_next = (wsxy < prod_reg[DW-1:0]);
                        num_m_next = (wsxy < prod_reg[DW-1:0]) ? prod_reg[DW-1:0] - wsxy
                                                               : wsxy - prod_reg[DW-1:0];
                    end
                    2'd2:
                    begin
                        p3_next = prod_reg;
                    end
                    default:
                    begin
                        neg_c_next = (p3_reg < prod_reg);
                        num_c_next = (p3_reg < prod_reg) ? prod_reg - p3_reg : p3_reg - prod_reg;
                        // All ticks equal in the window: no fit is possible.
                        if (den_reg == '0)
                        begin
                            failed_next    = 1'b1;
                            slope_res_next = '0;
                            icpt_res_next  = '0;
                            state_next     = ST_OUT;
                        end
                        else
                        begin
                            failed_next = 1'b0;
                            dsel_next   = 1'b0;
                            state_next  = ST_DLOAD;
                        end
                    end
                endcase
            end
            ST_DLOAD:
            begin
                rem_next  = '0;
                dcnt_next = '0;
                if (!dsel_reg)
                begin
                    num_next = {(NW - DW)'(0), num_m_reg, 16'd0};
                end
                else
                begin
                    num_next = {num_c_reg, 16'd0};
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // Quotient bits shift in at the bottom as dividend bits leave the top.
                rem_next  = div_ge ? DW'(div_sh - {1'b0, den_reg}) : div_sh[DW-1:0];
                num_next  = {num_reg[QNW-2:0], div_ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(QNW - 1))
                begin
                    state_next = ST_DSTORE;
                end
            end
            ST_DSTORE:
            begin
                if (!dsel_reg)
                begin
                    if (!neg_m_reg)
                    begin
                        slope_res_next = sl_over_p ? {1'b0, {(SLW - 1){1'b1}}} : num_reg[SLW-1:0];
                    end
                    else
                    begin
                        slope_res_next = sl_over_n ? {1'b1, {(SLW - 1){1'b0}}}
                                                   : SLW'(0) - num_reg[SLW-1:0];
                    end
                    dsel_next  = 1'b1;
                    state_next = ST_DLOAD;
                end
                else
                begin
                    if (!neg_c_reg)
                    begin
                        icpt_res_next = ic_over_p ? {1'b0, {(ICW - 1){1'b1}}} : num_reg[ICW-1:0];
                    end
                    else
                    begin
                        icpt_res_next = ic_over_n ? {1'b1, {(ICW - 1){1'b0}}}
                                                  : ICW'(0) - num_reg[ICW-1:0];
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {icpt_res_reg, slope_res_reg};
                    out_fail_next  = failed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sim/windowed_line_fit_checker.sv
`timescale 1ns / 1ps

module windowed_line_fit_checker
    import wlf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [47:0] intercept;
        logic               failed;
    } fit_t;

    logic [31:0] ticks [WINDOW];
    logic [31:0] times [WINDOW];
    int          slot;
    fit_t        fit_queue[$];

    assign pending = fit_queue.size();

    // Scaled num / den with truncation toward zero, clamped to a signed field.
    function automatic logic [63:0] scaled_ratio(input logic signed [199:0] num,
                                                 input logic signed [199:0] den,
                                                 input int bits);
        logic signed [199:0] q;
        logic signed [199:0] hi;
        logic signed [199:0] lo;
        q  = (num * 200'sd65536) / den;
        hi = (200'sd1 <<< (bits - 1)) - 200'sd1;
        lo = -(200'sd1 <<< (bits - 1));
        if (q > hi)
            q = hi;
        if (q < lo)
            q = lo;
        return q[63:0];
    endfunction

    function automatic fit_t fit_window();
        logic signed [199:0] sx, sy, sxx, sxy, n, den, num_m, num_c;
        fit_t f;
        sx = 0; sy = 0; sxx = 0; sxy = 0;
        n = WINDOW;
        for (int k = 0; k < WINDOW; k++)
        begin
            sx  += $signed({168'd0, ticks[k]});
            sy  += $signed({168'd0, times[k]});
            sxx += $signed({168'd0, ticks[k]}) * $signed({168'd0, ticks[k]});
            sxy += $signed({168'd0, ticks[k]}) * $signed({168'd0, times[k]});
        end
        den = n * sxx - sx * sx;
        f = '0;
        if (den == 0)
            f.failed = 1'b1;
        else
        begin
            num_m = n * sxy - sx * sy;
            num_c = sy * sxx - sx * sxy;
            f.slope     = 32'(scaled_ratio(num_m, den, 32));
            f.intercept = 48'(scaled_ratio(num_c, den, 48));
        end
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fit_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW; k++)
            begin
                ticks[k] = '0;
                times[k] = '0;
            end
            slot = 0;
            fail_count = 0;
            fit_queue.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                ticks[slot] = s_axis_tdata[31:0];
                times[slot] = s_axis_tdata[63:32];
                slot = (slot + 1) % WINDOW;
                fit_queue.push_back(fit_window());
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (fit_queue.size() == 0)
                begin
                    $error("result beat with no fit expected");
                    fail_count++;
                end
                else
                begin
                    want = fit_queue.pop_front();
                    if (m_axis_tdata[31:0] !== want.slope)
                    begin
                        $error("slope: expected %0d, got %0d", want.slope,
                               $signed(m_axis_tdata[31:0]));
                        fail_count++;
                    end
                    if (m_axis_tdata[79:32] !== want.intercept)
                    begin
                        $error("intercept: expected %0d, got %0d", want.intercept,
                               $signed(m_axis_tdata[79:32]));
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== want.failed)
                    begin
                        $error("fit_failed: expected %0d, got %0d", want.failed,
                               m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: sim/windowed_line_fit_tb.sv
`timescale 1ns / 1ps

module windowed_line_fit_tb;

    import wlf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [31:0] tick_base;

    always #4 clk = ~clk;

    windowed_line_fit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    windowed_line_fit_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Called at a falling edge; returns at the falling edge after the accepting edge.
    // Valid stays high on return, since ready stays low after a beat until its fit is done.
    task automatic send_beat(input logic [31:0] tick, input logic [31:0] ltime);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ltime, tick};
        // Ready is stable between edges, so it is checked at the falling edge.
        while (!s_axis_tready)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Mostly steady heartbeats: ticks counting up with a jittered time per tick.
    task automatic send_random_beat();
        logic [31:0] tick;
        logic [31:0] ltime;
        case ($urandom_range(9))
            0, 1:
            begin
                tick  = $urandom;
                ltime = $urandom;
            end
            2:
            begin
                tick  = tick_base;
                ltime = $urandom;
            end
            default:
            begin
                tick_base = tick_base + $urandom_range(3);
                tick  = tick_base;
                ltime = tick_base * ($urandom_range(1200, 800)) + $urandom_range(50);
            end
        endcase
        send_beat(tick, ltime);
    endtask

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        tick_base = $urandom;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty window, equal ticks, extremes, steep and flat lines.
        send_beat(32'd0, 32'd0);
        send_beat(32'd0, 32'hFFFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'd0);
        send_beat(32'd1, 32'hFFFF_FFFF);
        send_beat(32'd2, 32'd0);
        send_beat(32'hFFFF_FFFE, 32'h8000_0000);
        send_beat(32'h8000_0000, 32'h7FFF_FFFF);
        for (int k = 0; k < 8; k++)
            send_beat(32'd5, 32'h5555_5555 ^ k);
        send_beat(32'd6, 32'hFFFF_FFFF);
        for (int k = 0; k < 6; k++)
            send_beat(32'd100 + k, 32'd1000 * k);
        send_beat(32'hAAAA_AAAA, 32'h5555_5555);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int k = 0; k < 135; k++)
            begin
                send_random_beat();
                if (phase == 1 && k == 60)
                begin
                    s_axis_tvalid <= 1'b0;
                    @(negedge clk);
                    while (pending != 0)
                        @(negedge clk);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (500) @(negedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
design/wlf_pkg.sv
design/windowed_line_fit.sv
sim/windowed_line_fit_checker.sv
sim/windowed_line_fit_tb.sv
